@@ design/fvc_pkg.sv @@
// Shared constants, wheel table and stage types for the flow color coder.
package fvc_pkg;

  localparam int WHEEL_SIZE   = 55;
  localparam int FRAC_BITS    = 6;
  localparam int SEG_RY       = 15;
  localparam int SEG_YG       = 6;
  localparam int SEG_GC       = 4;
  localparam int SEG_CB       = 11;
  localparam int SEG_BM       = 13;
  localparam int SEG_MR       = 6;
  localparam int WHEEL_BASE   = SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM + SEG_MR;

  localparam int FLOW_W       = 16;
  localparam int SQ_STEPS     = 32;
  localparam int ROOT_W       = 32;
  localparam int REM_W        = 34;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_SH    = 14;
  localparam int CX_W         = 33;
  localparam int ANG_W        = 16;
  localparam int MAX_W        = 16;
  localparam int M_W          = MAX_W + FRAC_BITS;
  localparam int DIV_STEPS    = 17;
  localparam int DV_W         = M_W + DIV_STEPS;
  localparam int KW           = $clog2(WHEEL_SIZE);
  localparam int POS_W        = ANG_W + KW;
  localparam int CH_W         = 24;
  localparam int PROD_W       = DIV_STEPS + CH_W;
  localparam int CHANNELS     = 3;
  localparam logic [CH_W-1:0] ONE = CH_W'(255) << 16;

  localparam logic [ANG_W-1:0] ANG_ZERO  = 16'h0000;
  localparam logic [ANG_W-1:0] ANG_QUART = 16'h4000;
  localparam logic [ANG_W-1:0] ANG_HALF  = 16'h8000;
  localparam logic [ANG_W-1:0] ANG_3QUART = 16'hC000;

  typedef struct packed {
    logic kind;
    logic fs;
    logic unk;
    logic axis;
  } side_t;

  function automatic logic [ANG_W-1:0] atan_turn(int i);
    logic [ANG_W-1:0] a;
    case (i)
      0: a = 16'd8192;
      1: a = 16'd4836;
      2: a = 16'd2555;
      3: a = 16'd1297;
      4: a = 16'd651;
      5: a = 16'd326;
      6: a = 16'd163;
      7: a = 16'd81;
      8: a = 16'd41;
      9: a = 16'd20;
      10: a = 16'd10;
      11: a = 16'd5;
      12: a = 16'd3;
      13: a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Entry n: {red, green, blue}.
  function automatic logic [WHEEL_SIZE*CH_W-1:0] build_wheel();
    logic [WHEEL_SIZE*CH_W-1:0] lut;
    int k;
    int i;
    int r;
    int g;
    int b;
    lut = '0;
    for (int n = 0; n < WHEEL_SIZE; n++) begin
      k = n % WHEEL_BASE;
      if (k < SEG_RY) begin
        i = k; r = 255; g = 255 * i / SEG_RY; b = 0;
      end else if (k < SEG_RY + SEG_YG) begin
        i = k - SEG_RY; r = 255 - 255 * i / SEG_YG; g = 255; b = 0;
      end else if (k < SEG_RY + SEG_YG + SEG_GC) begin
        i = k - SEG_RY - SEG_YG; r = 0; g = 255; b = 255 * i / SEG_GC;
      end else if (k < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
        i = k - SEG_RY - SEG_YG - SEG_GC; r = 0; g = 255 - 255 * i / SEG_CB; b = 255;
      end else if (k < WHEEL_BASE - SEG_MR) begin
        i = k - (WHEEL_BASE - SEG_MR - SEG_BM); r = 255 * i / SEG_BM; g = 0; b = 255;
      end else begin
        i = k - (WHEEL_BASE - SEG_MR); r = 255; g = 0; b = 255 - 255 * i / SEG_MR;
      end
      lut[n*CH_W +: CH_W] = {8'(r), 8'(g), 8'(b)};
    end
    return lut;
  endfunction

  localparam logic [WHEEL_SIZE*CH_W-1:0] WHEEL_LUT = build_wheel();

endpackage

@@ design/flow_vector_to_color.sv @@
// Flow vector to hue-wheel color coder, deep pipeline top level.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   in       | in_valid / in_ready    | kind frame_start unknown flow_u flow_v
//   out      | out_valid / out_ready  | red green blue
//   cfg      | cfg_valid / cfg_ready  | max_motion
//
// One request enters per cycle while the output is not stalled; the pipeline
// depth is set by the 32-step square root and the 17-step radius divider.
// Reset clears valid bits, the measured maximum and motion_limit.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module flow_vector_to_color (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic        frame_start,
  input  logic        unknown,
  input  logic signed [15:0] flow_u,
  input  logic signed [15:0] flow_v,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_motion
);

  localparam int SQ = fvc_pkg::SQ_STEPS;
  localparam int DS = fvc_pkg::DIV_STEPS;

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  logic [fvc_pkg::MAX_W-1:0] motion_limit;
  logic [fvc_pkg::MAX_W-1:0] meas;
  logic [fvc_pkg::MAX_W-1:0] meas_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_limit <= '0;
    end else if (cfg_valid) begin
      motion_limit <= max_motion;
    end
  end

  // Stage 0: squares.
  logic               vld0;
  fvc_pkg::side_t     sd0;
  logic signed [15:0] u0, v0;
  logic [31:0]        uu0, vv0;
  logic signed [31:0] uu_w, vv_w;

  assign uu_w = flow_u * flow_u;
  assign vv_w = flow_v * flow_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (adv) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd0 <= '{kind: kind, fs: frame_start, unk: unknown, axis: 1'b0};
      u0  <= flow_u;
      v0  <= flow_v;
      uu0 <= uu_w;
      vv0 <= vv_w;
    end
  end

  // Stage 1 feeds index 0 of the root / angle pipeline.
  logic                                vq   [0:SQ];
  fvc_pkg::side_t                      sq   [0:SQ];
  logic [31:0]                         s_q  [0:SQ];
  logic [fvc_pkg::ROOT_W-1:0]          root [0:SQ];
  logic [fvc_pkg::REM_W-1:0]           rem  [0:SQ];
  logic signed [fvc_pkg::CX_W-1:0]     cx   [0:SQ];
  logic signed [fvc_pkg::CX_W-1:0]     cy   [0:SQ];
  logic [fvc_pkg::ANG_W-1:0]           ang  [0:SQ];

  logic signed [fvc_pkg::CX_W-1:0] ux, vy;
  logic                            axis1;
  logic [fvc_pkg::ANG_W-1:0]       axis_ang;

  assign ux    = fvc_pkg::CX_W'(u0) <<< fvc_pkg::CORDIC_SH;
  assign vy    = fvc_pkg::CX_W'(v0) <<< fvc_pkg::CORDIC_SH;
  assign axis1 = (v0 == 16'sd0) || (u0 == 16'sd0);

  always_comb begin
    priority if (v0 == 16'sd0) begin
      axis_ang = (u0 < 16'sd0) ? fvc_pkg::ANG_HALF : fvc_pkg::ANG_ZERO;
    end else begin
      axis_ang = (v0 > 16'sd0) ? fvc_pkg::ANG_QUART : fvc_pkg::ANG_3QUART;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else if (adv) begin
      vq[0] <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0]   <= '{kind: sd0.kind, fs: sd0.fs, unk: sd0.unk, axis: axis1};
      s_q[0]  <= uu0 + vv0;
      root[0] <= '0;
      rem[0]  <= '0;
      if (u0 < 16'sd0) begin
        cx[0]  <= -ux;
        cy[0]  <= -vy;
        ang[0] <= axis1 ? axis_ang : fvc_pkg::ANG_HALF;
      end else begin
        cx[0]  <= ux;
        cy[0]  <= vy;
        ang[0] <= axis1 ? axis_ang : fvc_pkg::ANG_ZERO;
      end
    end
  end

  // Root digit per stage on {s, 32'b0}; CORDIC rotation in the first stages.
  for (genvar j = 0; j < SQ; j++) begin : g_sq
    localparam int I = SQ - 1 - j;
    logic [1:0]                      digit;
    logic [fvc_pkg::REM_W+1:0]       rem_sh;
    logic [fvc_pkg::REM_W-1:0]       trial;
    logic                            ge;
    logic signed [fvc_pkg::CX_W-1:0] cx_n, cy_n;
    logic [fvc_pkg::ANG_W-1:0]       ang_n;

    if (I >= 16) begin : g_dig
      assign digit = s_q[j][2*(I-16) +: 2];
    end else begin : g_zero
      assign digit = 2'b00;
    end

    assign rem_sh = {rem[j], digit};
    assign trial  = {root[j], 2'b01};
    assign ge     = rem_sh >= (fvc_pkg::REM_W+2)'(trial);

    if (j < fvc_pkg::CORDIC_STEPS) begin : g_rot
      always_comb begin
        cx_n  = cx[j];
        cy_n  = cy[j];
        ang_n = ang[j];
        if (!sq[j].axis) begin
          if (cy[j] >= 0) begin
            cx_n  = cx[j] + (cy[j] >>> j);
            cy_n  = cy[j] - (cx[j] >>> j);
            ang_n = ang[j] + fvc_pkg::atan_turn(j);
          end else begin
            cx_n  = cx[j] - (cy[j] >>> j);
            cy_n  = cy[j] + (cx[j] >>> j);
            ang_n = ang[j] - fvc_pkg::atan_turn(j);
          end
        end
      end
    end else begin : g_pass
      assign cx_n  = cx[j];
      assign cy_n  = cy[j];
      assign ang_n = ang[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[j+1] <= 1'b0;
      end else if (adv) begin
        vq[j+1] <= vq[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j+1]  <= sq[j];
        s_q[j+1] <= s_q[j];
        cx[j+1]  <= cx_n;
        cy[j+1]  <= cy_n;
        ang[j+1] <= ang_n;
        if (ge) begin
          rem[j+1]  <= fvc_pkg::REM_W'(rem_sh - (fvc_pkg::REM_W+2)'(trial));
          root[j+1] <= {root[j][fvc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem[j+1]  <= fvc_pkg::REM_W'(rem_sh);
          root[j+1] <= {root[j][fvc_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Running maximum; color requests read it here, after all earlier measures.
  logic [fvc_pkg::MAX_W-1:0] r_int;
  logic [fvc_pkg::MAX_W-1:0] meas_base;
  logic [fvc_pkg::M_W-1:0]   m_sel;
  logic                      ovf;

  assign r_int     = root[SQ][fvc_pkg::ROOT_W-1 -: fvc_pkg::MAX_W];
  assign meas_base = sq[SQ].fs ? '0 : meas;
  assign meas_next = (!sq[SQ].unk && r_int > meas_base) ? r_int : meas_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas <= '0;
    end else if (adv && vq[SQ] && !sq[SQ].kind) begin
      meas <= meas_next;
    end
  end

  always_comb begin
    priority if (motion_limit != '0) begin
      m_sel = fvc_pkg::M_W'(motion_limit) << fvc_pkg::FRAC_BITS;
    end else if (meas != '0) begin
      m_sel = fvc_pkg::M_W'(meas);
    end else begin
      m_sel = fvc_pkg::M_W'(1) << fvc_pkg::FRAC_BITS;
    end
  end

  assign ovf = fvc_pkg::DV_W'(root[SQ]) >= (fvc_pkg::DV_W'(m_sel) << DS);

  // Radius divider, one quotient bit per stage; wheel blend rides alongside.
  logic                         dvld [0:DS];
  logic                         dunk [0:DS];
  logic                         dovf [0:DS];
  logic [fvc_pkg::ROOT_W-1:0]   drem [0:DS];
  logic [DS-1:0]                dq   [0:DS];
  logic [fvc_pkg::M_W-1:0]      dm   [0:DS];
  logic [fvc_pkg::ANG_W-1:0]    dt   [0:DS];
  logic [fvc_pkg::KW-1:0]       dk0  [0:DS];
  logic [15:0]                  df   [0:DS];
  logic [fvc_pkg::CH_W-1:0]     dc   [0:DS][fvc_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (adv) begin
      dvld[0] <= vq[SQ] && sq[SQ].kind;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dunk[0] <= sq[SQ].unk;
      dovf[0] <= ovf;
      drem[0] <= root[SQ];
      dq[0]   <= '0;
      dm[0]   <= m_sel;
      dt[0]   <= ang[SQ];
      dk0[0]  <= '0;
      df[0]   <= '0;
      for (int c = 0; c < fvc_pkg::CHANNELS; c++) begin
        dc[0][c] <= '0;
      end
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    localparam int B = DS - 1 - k;
    logic [fvc_pkg::DV_W-1:0]  dv;
    logic                      ge;
    logic [fvc_pkg::KW-1:0]    k0_n;
    logic [15:0]               f_n;
    logic [fvc_pkg::CH_W-1:0]  c_n [fvc_pkg::CHANNELS];

    assign dv = fvc_pkg::DV_W'(dm[k]) << B;
    assign ge = fvc_pkg::DV_W'(drem[k]) >= dv;

    if (k == 0) begin : g_pos
      logic [fvc_pkg::POS_W-1:0] p;
      assign p    = fvc_pkg::POS_W'(dt[k]) * fvc_pkg::POS_W'(fvc_pkg::WHEEL_SIZE - 1);
      assign k0_n = p[fvc_pkg::POS_W-1 -: fvc_pkg::KW];
      assign f_n  = p[15:0];
    end else begin : g_pos_pass
      assign k0_n = dk0[k];
      assign f_n  = df[k];
    end

    if (k == 1) begin : g_blend
      logic [fvc_pkg::KW-1:0]   k1;
      logic [fvc_pkg::CH_W-1:0] w0, w1;
      logic [16:0]              fa, fb;
      assign k1 = (dk0[k] == fvc_pkg::KW'(fvc_pkg::WHEEL_SIZE - 1)) ? '0 : dk0[k] + 1'b1;
      assign w0 = fvc_pkg::WHEEL_LUT[dk0[k]*fvc_pkg::CH_W +: fvc_pkg::CH_W];
      assign w1 = fvc_pkg::WHEEL_LUT[k1*fvc_pkg::CH_W +: fvc_pkg::CH_W];
      assign fa = 17'h10000 - 17'(df[k]);
      assign fb = 17'(df[k]);
      for (genvar c = 0; c < fvc_pkg::CHANNELS; c++) begin : g_ch
        logic [7:0] a0, a1;
        assign a0 = w0[(fvc_pkg::CHANNELS-1-c)*8 +: 8];
        assign a1 = w1[(fvc_pkg::CHANNELS-1-c)*8 +: 8];
        assign c_n[c] = fvc_pkg::CH_W'(fa * 25'(a0)) + fvc_pkg::CH_W'(fb * 25'(a1));
      end
    end else begin : g_blend_pass
      assign c_n = dc[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (adv) begin
        dvld[k+1] <= dvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dunk[k+1] <= dunk[k];
        dovf[k+1] <= dovf[k];
        dm[k+1]   <= dm[k];
        dt[k+1]   <= dt[k];
        dk0[k+1]  <= k0_n;
        df[k+1]   <= f_n;
        dc[k+1]   <= c_n;
        if (ge) begin
          drem[k+1] <= drem[k] - fvc_pkg::ROOT_W'(dv);
          dq[k+1]   <= dq[k] | (DS'(1) << B);
        end else begin
          drem[k+1] <= drem[k];
          dq[k+1]   <= dq[k];
        end
      end
    end
  end

  // Blend toward white inside the unit radius, scale by 3/4 outside; unknown vectors come out black.
  logic                        pvld;
  logic                        punk;
  logic                        pin;
  logic [fvc_pkg::PROD_W-1:0]  prod [fvc_pkg::CHANNELS];
  logic [7:0]                  pout [fvc_pkg::CHANNELS];
  logic                        in_unit;

  assign in_unit = !dovf[DS] && (dq[DS] <= DS'(17'h10000));

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else if (adv) begin
      pvld <= dvld[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      punk <= dunk[DS];
      pin  <= in_unit;
      for (int c = 0; c < fvc_pkg::CHANNELS; c++) begin
        prod[c] <= fvc_pkg::PROD_W'(dq[DS]) * fvc_pkg::PROD_W'(fvc_pkg::ONE - dc[DS][c]);
        pout[c] <= 8'((26'(dc[DS][c]) + (26'(dc[DS][c]) << 1)) >> 18);
      end
    end
  end

  logic [7:0] fin [fvc_pkg::CHANNELS];

  for (genvar c = 0; c < fvc_pkg::CHANNELS; c++) begin : g_fin
    logic [24:0] tmp;
    assign tmp    = 25'(fvc_pkg::ONE) - prod[c][fvc_pkg::PROD_W-1:16];
    assign fin[c] = punk ? 8'd0 : (pin ? tmp[23:16] : pout[c]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pvld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red   <= fin[0];
      green <= fin[1];
      blue  <= fin[2];
    end
  end

endmodule

@@ design/fvc_checker.sv @@
// Port-level checks for the flow color coder, bound to the top level.
module fvc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cfg_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
    else $error("output request changed while stalled");

  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind flow_vector_to_color fvc_checker u_fvc_checker (.*);
